// ===== design/ecpa_pkg.sv =====
// Shared types, codes and field helpers for the elliptic-curve point unit.
// No dependencies; used by the field arithmetic unit and the top level.
package ecpa_pkg;

	// width of a reduced field element (the modulus register is 16 bits)
	localparam int FW = 16;

	// configuration register indexes
	localparam logic CFG_PRIME   = 1'b0;
	localparam logic CFG_COEFF_A = 1'b1;

	// operations of the shared field unit
	typedef enum logic [2:0] {
		FU_ADD = 3'd0,
		FU_SUB = 3'd1,
		FU_MOD = 3'd2,
		FU_MUL = 3'd3,
		FU_INV = 3'd4
	} fu_op_t;

	typedef struct packed {
		logic   start;
		fu_op_t op;
	} fu_ctl_t;

	typedef struct packed {
		logic done;
		logic ok;
	} fu_sts_t;

	// modular add of two reduced values
	function automatic logic [FW-1:0] fadd(input logic [FW-1:0] a, input logic [FW-1:0] b,
		input logic [FW-1:0] p);
		logic [FW-1:0] d;
		d = p - b;
		fadd = (a >= d) ? a - d : a + b;
	endfunction

	// modular subtract of two reduced values
	function automatic logic [FW-1:0] fsub(input logic [FW-1:0] a, input logic [FW-1:0] b,
		input logic [FW-1:0] p);
		fsub = (a >= b) ? a - b : a + (p - b);
	endfunction

endpackage

// ===== design/ecpa_if.sv =====
// Request channels of the elliptic-curve point unit: input point request
// and result request, each with valid/ready. No dependencies.
interface ecpa_in_if #(parameter int FIELD_BITS = 16, parameter int SCALAR_BITS = 16);
	logic                   valid;
	logic                   ready;
	logic                   mode;
	logic [FIELD_BITS-1:0]  p_x;
	logic [FIELD_BITS-1:0]  p_y;
	logic [FIELD_BITS-1:0]  q_x;
	logic [FIELD_BITS-1:0]  q_y;
	logic [SCALAR_BITS-1:0] scalar;
	modport source (output valid, mode, p_x, p_y, q_x, q_y, scalar, input ready);
	modport sink (input valid, mode, p_x, p_y, q_x, q_y, scalar, output ready);
endinterface

interface ecpa_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] r_x;
	logic [15:0] r_y;
	logic        at_infinity;
	modport source (output valid, r_x, r_y, at_infinity, input ready);
	modport sink (input valid, r_x, r_y, at_infinity, output ready);
endinterface

// ===== design/ecpa_field_unit.sv =====
// Shared modular arithmetic unit: add, subtract, reduce, bit-serial multiply
// and extended-Euclid inverse. Depends on ecpa_pkg.
module ecpa_field_unit #(
	parameter int AW = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ecpa_pkg::fu_ctl_t         ctl,
	input  logic [AW-1:0]             opa,
	input  logic [ecpa_pkg::FW-1:0]   opb,
	input  logic [ecpa_pkg::FW-1:0]   prime,
	output logic [ecpa_pkg::FW-1:0]   res,
	output ecpa_pkg::fu_sts_t         sts
);
	localparam int FW = ecpa_pkg::FW;
	localparam int CW = $clog2(AW);

	typedef enum logic [4:0] {
		F_IDLE = 5'b00001,
		F_MOD  = 5'b00010,
		F_MUL  = 5'b00100,
		F_DIV  = 5'b01000,
		F_IMUL = 5'b10000
	} fstate_t;

	fstate_t        st_q;
	logic [CW-1:0]  cnt_q;
	logic [FW-1:0]  acc_q;
	logic [AW-1:0]  opa_q;
	logic [FW-1:0]  opb_q;
	logic [FW-1:0]  rem_q;
	logic [FW-1:0]  quo_q;
	logic [FW-1:0]  r1_q;
	logic [FW-1:0]  t0_q;
	logic [FW-1:0]  t1_q;
	logic [FW-1:0]  res_q;
	logic           ok_q;
	logic           done_q;

	// one step of each iteration
	logic [FW:0]    mod_t;
	logic [FW-1:0]  mod_r;
	logic [FW-1:0]  dbl;
	logic [FW-1:0]  mul_r;
	logic [FW:0]    div_t;
	logic           div_ge;
	logic [FW-1:0]  div_r;
	logic [FW-1:0]  nt;

	always_comb begin
		mod_t  = {acc_q, opa_q[AW-1]};
		mod_r  = (mod_t >= {1'b0, prime}) ? FW'(mod_t - {1'b0, prime}) : mod_t[FW-1:0];
		dbl    = ecpa_pkg::fadd(acc_q, acc_q, prime);
		if (st_q == F_IMUL)
			mul_r = opb_q[FW-1] ? ecpa_pkg::fadd(dbl, t1_q, prime) : dbl;
		else
			mul_r = opb_q[FW-1] ? ecpa_pkg::fadd(dbl, opa_q[FW-1:0], prime) : dbl;
		div_t  = {rem_q, opb_q[FW-1]};
		div_ge = div_t >= {1'b0, r1_q};
		div_r  = div_ge ? FW'(div_t - {1'b0, r1_q}) : div_t[FW-1:0];
		nt     = ecpa_pkg::fsub(t0_q, mul_r, prime);
	end

	// sequence the selected operation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= F_IDLE;
			done_q <= 1'b0;
		end else begin
			case (st_q)
				F_IDLE: begin
					if (ctl.start) begin
						case (ctl.op)
							ecpa_pkg::FU_ADD: begin
								res_q  <= ecpa_pkg::fadd(opa[FW-1:0], opb, prime);
								done_q <= 1'b1;
							end
							ecpa_pkg::FU_SUB: begin
								res_q  <= ecpa_pkg::fsub(opa[FW-1:0], opb, prime);
								done_q <= 1'b1;
							end
							ecpa_pkg::FU_MOD: begin
								acc_q  <= '0;
								opa_q  <= opa;
								cnt_q  <= CW'(AW - 1);
								done_q <= 1'b0;
								st_q   <= F_MOD;
							end
							ecpa_pkg::FU_MUL: begin
								acc_q  <= '0;
								opa_q  <= opa;
								opb_q  <= opb;
								cnt_q  <= CW'(FW - 1);
								done_q <= 1'b0;
								st_q   <= F_MUL;
							end
							ecpa_pkg::FU_INV: begin
								r1_q  <= opa[FW-1:0];
								t0_q  <= '0;
								t1_q  <= FW'(1);
								opb_q <= prime;
								rem_q <= '0;
								quo_q <= '0;
								cnt_q <= CW'(FW - 1);
								if (opa[FW-1:0] == '0) begin
									// zero has no inverse
									ok_q   <= 1'b0;
									done_q <= 1'b1;
								end else begin
									done_q <= 1'b0;
									st_q   <= F_DIV;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end else begin
						done_q <= 1'b0;
					end
				end
				F_MOD: begin
					acc_q  <= mod_r;
					opa_q  <= opa_q << 1;
					cnt_q  <= cnt_q - 1'b1;
					done_q <= (cnt_q == '0);
					if (cnt_q == '0) begin
						res_q <= mod_r;
						st_q  <= F_IDLE;
					end
				end
				F_MUL: begin
					acc_q  <= mul_r;
					opb_q  <= opb_q << 1;
					cnt_q  <= cnt_q - 1'b1;
					done_q <= (cnt_q == '0);
					if (cnt_q == '0) begin
						res_q <= mul_r;
						st_q  <= F_IDLE;
					end
				end
				F_DIV: begin
					// restoring division r0 / r1, quotient into opb for the multiply
					rem_q  <= div_r;
					quo_q  <= {quo_q[FW-2:0], div_ge};
					done_q <= 1'b0;
					if (cnt_q == '0) begin
						opb_q <= {quo_q[FW-2:0], div_ge};
						acc_q <= '0;
						cnt_q <= CW'(FW - 1);
						st_q  <= F_IMUL;
					end else begin
						opb_q <= opb_q << 1;
						cnt_q <= cnt_q - 1'b1;
					end
				end
				F_IMUL: begin
					acc_q  <= mul_r;
					done_q <= (cnt_q == '0) && (rem_q == '0);
					if (cnt_q == '0) begin
						// advance the remainder and coefficient sequences
						r1_q <= rem_q;
						t0_q <= t1_q;
						t1_q <= nt;
						if (rem_q == '0) begin
							ok_q  <= (r1_q == FW'(1));
							res_q <= t1_q;
							st_q  <= F_IDLE;
						end else begin
							opb_q <= r1_q;
							rem_q <= '0;
							quo_q <= '0;
							cnt_q <= CW'(FW - 1);
							st_q  <= F_DIV;
						end
					end else begin
						opb_q <= opb_q << 1;
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: begin
					done_q <= 1'b0;
					st_q   <= F_IDLE;
				end
			endcase
		end
	end

	assign res      = res_q;
	assign sts.done = done_q;
	assign sts.ok   = ok_q;

endmodule

// ===== design/ec_point_add_scalar_mult_unit.sv =====
// Top level of the elliptic-curve point unit: sequencer, point registers,
// configuration registers. Depends on ecpa_pkg, ecpa_if and ecpa_field_unit.
//
// Usage: in_chan carries one request (mode, P, Q, scalar); out_chan returns
// one result (r_x, r_y, at_infinity) for each request. mode 0 adds P and Q,
// mode 1 multiplies P by the scalar with left-to-right double-and-add.
// The block takes one request at a time: in_chan.ready is high only while
// idle. Reductions, multiplies and inverses run on one shared field unit,
// and each operation holds it from its start cycle to its done cycle; an
// inverse runs one restoring division and one multiply per Euclid round.
// Unless the modulus is below two, every request first reduces the
// coefficient and the four input coordinates. A doubling adds one square
// to a point add; an add with or to infinity, or of two points with equal
// x and different y, uses no field operation. A scalar request costs one
// point double per scalar bit plus one add per set bit, so up to
// 2*SCALAR_BITS point adds.
// The result register holds until out_chan.ready; a stalled receiver stops
// nothing else, the block simply stays busy until the result is taken.
// Reset loads modulus 97 and coefficient 2 and leaves the block idle.
// Configuration writes (cfg_we, cfg_index, cfg_data) are for the user to
// make only while idle; the block itself does not enforce this.
module ec_point_add_scalar_mult_unit #(
	parameter int FIELD_BITS  = 16,
	parameter int SCALAR_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	ecpa_in_if.sink     in_chan,
	ecpa_out_if.source  out_chan
);
	localparam int FW  = ecpa_pkg::FW;
	localparam int AW  = (FIELD_BITS > FW) ? FIELD_BITS : FW;
	localparam int SIW = (SCALAR_BITS > 1) ? $clog2(SCALAR_BITS) : 1;

	// load steps
	localparam logic [2:0] LD_A  = 3'd0;
	localparam logic [2:0] LD_PX = 3'd1;
	localparam logic [2:0] LD_PY = 3'd2;
	localparam logic [2:0] LD_QX = 3'd3;
	localparam logic [2:0] LD_QY = 3'd4;
	// point add steps
	localparam logic [2:0] AD_CHK = 3'd0;
	localparam logic [2:0] AD_SQ  = 3'd1;
	localparam logic [2:0] AD_INV = 3'd2;
	localparam logic [2:0] AD_LAM = 3'd3;
	localparam logic [2:0] AD_L2  = 3'd4;
	localparam logic [2:0] AD_Y   = 3'd5;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_LOAD = 5'b00010,
		S_ADD  = 5'b00100,
		S_NEXT = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t                 state_q;
	logic [2:0]             step_q;
	logic                   issued_q;
	logic [FW-1:0]          prime_q;
	logic [FW-1:0]          coeff_q;
	logic                   mode_q;
	logic [AW-1:0]          px_raw_q;
	logic [AW-1:0]          py_raw_q;
	logic [AW-1:0]          qx_raw_q;
	logic [AW-1:0]          qy_raw_q;
	logic [SCALAR_BITS-1:0] k_q;
	logic [SIW-1:0]         idx_q;
	logic                   dbl_phase_q;
	logic [FW-1:0]          ac_q;
	logic [FW-1:0]          px_q;
	logic [FW-1:0]          py_q;
	logic [FW-1:0]          rx_q;
	logic [FW-1:0]          ry_q;
	logic                   rinf_q;
	logic [FW-1:0]          bx_q;
	logic [FW-1:0]          by_q;
	logic                   binf_q;
	logic [FW-1:0]          num_q;
	logic [FW-1:0]          den_q;
	logic [FW-1:0]          lam_q;
	logic [FW-1:0]          xr_q;

	ecpa_pkg::fu_ctl_t      fu_ctl;
	ecpa_pkg::fu_sts_t      fu_sts;
	logic [AW-1:0]          fu_a;
	logic [FW-1:0]          fu_b;
	logic [FW-1:0]          fu_res;
	logic                   p_inf;
	logic [FW-1:0]          sq3;

	ecpa_field_unit #(.AW(AW)) u_fu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (fu_ctl),
		.opa    (fu_a),
		.opb    (fu_b),
		.prime  (prime_q),
		.res    (fu_res),
		.sts    (fu_sts)
	);

	assign p_inf = (px_q == '0) && (py_q == '0);
	assign sq3   = ecpa_pkg::fadd(ecpa_pkg::fadd(ecpa_pkg::fadd(fu_res, fu_res, prime_q),
		fu_res, prime_q), ac_q, prime_q);

	// pick the field operation for the current step
	always_comb begin
		fu_ctl.start = 1'b0;
		fu_ctl.op    = ecpa_pkg::FU_MOD;
		fu_a         = '0;
		fu_b         = '0;
		case (state_q)
			S_LOAD: begin
				fu_ctl.start = !issued_q;
				fu_ctl.op    = ecpa_pkg::FU_MOD;
				case (step_q)
					LD_A:    fu_a = AW'(coeff_q);
					LD_PX:   fu_a = px_raw_q;
					LD_PY:   fu_a = py_raw_q;
					LD_QX:   fu_a = qx_raw_q;
					default: fu_a = qy_raw_q;
				endcase
			end
			S_ADD: begin
				fu_ctl.start = !issued_q && (step_q != AD_CHK);
				fu_ctl.op    = ecpa_pkg::FU_MUL;
				case (step_q)
					AD_SQ: begin
						fu_a = AW'(rx_q);
						fu_b = rx_q;
					end
					AD_INV: begin
						fu_ctl.op = ecpa_pkg::FU_INV;
						fu_a      = AW'(den_q);
					end
					AD_LAM: begin
						fu_a = AW'(num_q);
						fu_b = lam_q;
					end
					AD_L2: begin
						fu_a = AW'(lam_q);
						fu_b = lam_q;
					end
					default: begin
						fu_a = AW'(lam_q);
						fu_b = ecpa_pkg::fsub(rx_q, xr_q, prime_q);
					end
				endcase
			end
			default: begin
				fu_ctl.start = 1'b0;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prime_q <= FW'(97);
			coeff_q <= FW'(2);
		end else if (cfg_we) begin
			case (cfg_index)
				ecpa_pkg::CFG_PRIME:   prime_q <= cfg_data;
				ecpa_pkg::CFG_COEFF_A: coeff_q <= cfg_data;
				default:               prime_q <= prime_q;
			endcase
		end
	end

	// request payload, held for the whole operation
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_chan.valid) begin
			mode_q   <= in_chan.mode;
			px_raw_q <= AW'(in_chan.p_x);
			py_raw_q <= AW'(in_chan.p_y);
			qx_raw_q <= AW'(in_chan.q_x);
			qy_raw_q <= AW'(in_chan.q_y);
			k_q      <= in_chan.scalar;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			step_q   <= '0;
			issued_q <= 1'b0;
			rinf_q   <= 1'b1;
		end else begin
			if (fu_sts.done)
				issued_q <= 1'b0;
			else if (fu_ctl.start)
				issued_q <= 1'b1;
			case (state_q)
				S_IDLE: begin
					if (in_chan.valid) begin
						step_q <= LD_A;
						if (prime_q < FW'(2)) begin
							rinf_q  <= 1'b1;
							state_q <= S_OUT;
						end else begin
							state_q <= S_LOAD;
						end
					end
				end
				S_LOAD: begin
					if (fu_sts.done) begin
						step_q <= (step_q == LD_QY) ? AD_CHK : step_q + 1'b1;
						case (step_q)
							LD_A:  ac_q <= fu_res;
							LD_PX: px_q <= fu_res;
							LD_PY: py_q <= fu_res;
							LD_QX: bx_q <= fu_res;
							default: begin
								by_q    <= fu_res;
								state_q <= S_ADD;
								if (!mode_q) begin
									rx_q   <= px_q;
									ry_q   <= py_q;
									rinf_q <= p_inf;
									binf_q <= (bx_q == '0) && (fu_res == '0);
								end else begin
									// start from infinity and double it first
									rinf_q      <= 1'b1;
									binf_q      <= 1'b1;
									idx_q       <= SIW'(SCALAR_BITS - 1);
									dbl_phase_q <= 1'b1;
								end
							end
						endcase
					end
				end
				S_ADD: begin
					case (step_q)
						AD_CHK: begin
							if (rinf_q) begin
								rx_q    <= bx_q;
								ry_q    <= by_q;
								rinf_q  <= binf_q;
								state_q <= S_NEXT;
							end else if (binf_q) begin
								state_q <= S_NEXT;
							end else if (rx_q == bx_q) begin
								if (ry_q != by_q) begin
									rinf_q  <= 1'b1;
									state_q <= S_NEXT;
								end else begin
									den_q  <= ecpa_pkg::fadd(ry_q, ry_q, prime_q);
									step_q <= AD_SQ;
								end
							end else begin
								num_q  <= ecpa_pkg::fsub(by_q, ry_q, prime_q);
								den_q  <= ecpa_pkg::fsub(bx_q, rx_q, prime_q);
								step_q <= AD_INV;
							end
						end
						AD_SQ: begin
							if (fu_sts.done) begin
								num_q  <= sq3;
								step_q <= AD_INV;
							end
						end
						AD_INV: begin
							if (fu_sts.done) begin
								if (!fu_sts.ok) begin
									rinf_q  <= 1'b1;
									state_q <= S_NEXT;
								end else begin
									lam_q  <= fu_res;
									step_q <= AD_LAM;
								end
							end
						end
						AD_LAM: begin
							if (fu_sts.done) begin
								lam_q  <= fu_res;
								step_q <= AD_L2;
							end
						end
						AD_L2: begin
							if (fu_sts.done) begin
								xr_q <= ecpa_pkg::fsub(ecpa_pkg::fsub(fu_res, rx_q, prime_q),
									bx_q, prime_q);
								step_q <= AD_Y;
							end
						end
						default: begin
							if (fu_sts.done) begin
								rx_q    <= xr_q;
								ry_q    <= ecpa_pkg::fsub(fu_res, ry_q, prime_q);
								rinf_q  <= 1'b0;
								state_q <= S_NEXT;
							end
						end
					endcase
				end
				S_NEXT: begin
					step_q <= AD_CHK;
					if (!mode_q) begin
						state_q <= S_OUT;
					end else if (dbl_phase_q && k_q[idx_q]) begin
						// add P after the double
						bx_q        <= px_q;
						by_q        <= py_q;
						binf_q      <= p_inf;
						dbl_phase_q <= 1'b0;
						state_q     <= S_ADD;
					end else if (idx_q == '0) begin
						state_q <= S_OUT;
					end else begin
						// drop to the next scalar bit and double
						idx_q       <= idx_q - 1'b1;
						bx_q        <= rx_q;
						by_q        <= ry_q;
						binf_q      <= rinf_q;
						dbl_phase_q <= 1'b1;
						state_q     <= S_ADD;
					end
				end
				S_OUT: begin
					if (out_chan.ready)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_chan.ready        = (state_q == S_IDLE);
	assign out_chan.valid       = (state_q == S_OUT);
	assign out_chan.r_x         = rinf_q ? '0 : rx_q;
	assign out_chan.r_y         = rinf_q ? '0 : ry_q;
	assign out_chan.at_infinity = rinf_q;

endmodule

// ===== sim/ec_point_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the elliptic-curve point unit: tracks the configuration
// writes, predicts each result and compares it. Depends on ecpa_pkg, ecpa_if.
module ec_point_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	ecpa_in_if          in_mon,
	ecpa_out_if         out_mon,
	output int          fail_count,
	output int          pending
);

	typedef struct {
		longint unsigned x;
		longint unsigned y;
		bit              inf;
	} ec_point_t;

	typedef struct {
		logic [15:0] r_x;
		logic [15:0] r_y;
		logic        at_infinity;
	} ec_result_t;

	logic [15:0] modulus;
	logic [15:0] coeff_a;
	ec_result_t  expected_points[$];

	function automatic ec_point_t infinity_point();
		ec_point_t r;
		r.x = 0;
		r.y = 0;
		r.inf = 1'b1;
		return r;
	endfunction

	// extended Euclid; ok stays low when the value shares a factor with p
	function automatic longint unsigned field_inverse(input longint unsigned a,
		input longint unsigned p, output bit ok);
		longint r0, r1, t0, t1, q, tmp;
		r0 = p;
		r1 = a;
		t0 = 0;
		t1 = 1;
		while (r1 != 0) begin
			q = r0 / r1;
			tmp = r0 - q * r1;
			r0 = r1;
			r1 = tmp;
			tmp = t0 - q * t1;
			t0 = t1;
			t1 = tmp;
		end
		ok = (r0 == 1);
		return ((t0 % longint'(p)) + longint'(p)) % longint'(p);
	endfunction

	function automatic ec_point_t point_sum(input ec_point_t a_pt, input ec_point_t b_pt,
		input longint unsigned p, input longint unsigned ca);
		longint unsigned num, den, inv, lam, xr, yr;
		bit ok;
		ec_point_t r;
		if (a_pt.inf)
			return b_pt;
		if (b_pt.inf)
			return a_pt;
		if (a_pt.x == b_pt.x) begin
			if (a_pt.y != b_pt.y)
				return infinity_point();
			num = (3 * ((a_pt.x * a_pt.x) % p) + ca) % p;
			den = (2 * a_pt.y) % p;
		end else begin
			num = (b_pt.y + p - a_pt.y) % p;
			den = (b_pt.x + p - a_pt.x) % p;
		end
		inv = field_inverse(den, p, ok);
		if (!ok)
			return infinity_point();
		lam = (num * inv) % p;
		xr = ((lam * lam) % p + 2 * p - a_pt.x - b_pt.x) % p;
		yr = ((lam * ((a_pt.x + p - xr) % p)) % p + p - a_pt.y) % p;
		r.x = xr;
		r.y = yr;
		r.inf = 1'b0;
		return r;
	endfunction

	// left-to-right double-and-add, all 16 scalar bits
	function automatic ec_point_t point_scale(input ec_point_t base, input logic [15:0] k,
		input longint unsigned p, input longint unsigned ca);
		ec_point_t r;
		r = infinity_point();
		for (int i = 15; i >= 0; i--) begin
			r = point_sum(r, r, p, ca);
			if (k[i])
				r = point_sum(r, base, p, ca);
		end
		return r;
	endfunction

	function automatic ec_point_t load_point(input logic [15:0] x, input logic [15:0] y,
		input longint unsigned p);
		ec_point_t r;
		r.x = x % p;
		r.y = y % p;
		r.inf = (r.x == 0 && r.y == 0);
		return r;
	endfunction

	function automatic ec_result_t predict_point(input logic md, input logic [15:0] px,
		input logic [15:0] py, input logic [15:0] qx, input logic [15:0] qy,
		input logic [15:0] k);
		longint unsigned p, ca;
		ec_point_t r;
		ec_result_t res;
		p = modulus;
		if (p < 2) begin
			r = infinity_point();
		end else begin
			ca = coeff_a % p;
			if (md == 1'b0)
				r = point_sum(load_point(px, py, p), load_point(qx, qy, p), p, ca);
			else
				r = point_scale(load_point(px, py, p), k, p, ca);
		end
		res.r_x = r.inf ? 16'd0 : r.x[15:0];
		res.r_y = r.inf ? 16'd0 : r.y[15:0];
		res.at_infinity = r.inf;
		return res;
	endfunction

	// follow the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus <= 16'd97;
			coeff_a <= 16'd2;
		end else if (cfg_we) begin
			if (cfg_index == ecpa_pkg::CFG_PRIME)
				modulus <= cfg_data;
			else
				coeff_a <= cfg_data;
		end
	end

	// predict on each accepted request, compare each returned result
	always @(posedge clk) begin
		ec_result_t want;
		if (!arst_n) begin
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (in_mon.valid && in_mon.ready)
				expected_points.push_back(predict_point(in_mon.mode, in_mon.p_x, in_mon.p_y,
					in_mon.q_x, in_mon.q_y, in_mon.scalar));
			if (out_mon.valid && out_mon.ready) begin
				if (expected_points.size() == 0) begin
					$display("%0t: unexpected result x=%0d y=%0d inf=%0b", $time,
						out_mon.r_x, out_mon.r_y, out_mon.at_infinity);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_points.pop_front();
					if (want.r_x !== out_mon.r_x || want.r_y !== out_mon.r_y ||
						want.at_infinity !== out_mon.at_infinity) begin
						$display("%0t: mismatch expected x=%0d y=%0d inf=%0b, got x=%0d y=%0d inf=%0b",
							$time, want.r_x, want.r_y, want.at_infinity,
							out_mon.r_x, out_mon.r_y, out_mon.at_infinity);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= expected_points.size();
		end
	end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the elliptic-curve point unit: clock, reset, stimulus
// and verdict. Depends on ecpa_pkg, ecpa_if, ec_point_checker and the RTL.
module tb_top;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;
	int          fail_count;
	int          pending;
	int          send_idle;
	int          recv_idle;
	int          add_count;
	int          scale_count;
	logic [15:0] cur_prime;

	ecpa_in_if  in_chan ();
	ecpa_out_if out_chan ();

	ec_point_add_scalar_mult_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_chan  (in_chan),
		.out_chan (out_chan)
	);

	ec_point_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_mon    (in_chan),
		.out_mon   (out_chan),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver stalls at random
	always @(posedge clk)
		out_chan.ready <= ($urandom_range(0, 99) >= recv_idle);

	// hold the request until accepted, idling before it at random
	task automatic send_request(input logic md, input logic [15:0] px, input logic [15:0] py,
		input logic [15:0] qx, input logic [15:0] qy, input logic [15:0] k);
		while ($urandom_range(0, 99) < send_idle) begin
			in_chan.valid <= 1'b0;
			@(posedge clk);
		end
		in_chan.valid  <= 1'b1;
		in_chan.mode   <= md;
		in_chan.p_x    <= px;
		in_chan.p_y    <= py;
		in_chan.q_x    <= qx;
		in_chan.q_y    <= qy;
		in_chan.scalar <= k;
		do
			@(posedge clk);
		while (!in_chan.ready);
		if (md)
			scale_count++;
		else
			add_count++;
	endtask

	// drain outstanding results, then write both registers
	task automatic set_curve(input logic [15:0] prime, input logic [15:0] ca);
		in_chan.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= ecpa_pkg::CFG_PRIME;
		cfg_data  <= prime;
		@(posedge clk);
		cfg_index <= ecpa_pkg::CFG_COEFF_A;
		cfg_data  <= ca;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_prime = prime;
	endtask

	// coordinate mostly reduced, sometimes the full 16-bit range
	function automatic logic [15:0] rand_coord();
		if (cur_prime < 2 || $urandom_range(0, 4) == 0)
			return 16'($urandom);
		return 16'($urandom_range(0, cur_prime - 1));
	endfunction

	// random request, with doubling, negation and infinity cases mixed in
	task automatic random_request();
		logic [15:0] px, py, qx, qy, k;
		int pick;
		px = rand_coord();
		py = rand_coord();
		qx = rand_coord();
		qy = rand_coord();
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			qx = px;
			qy = py;
		end else if (pick == 1 && cur_prime >= 2) begin
			qx = px;
			qy = 16'((cur_prime - (py % cur_prime)) % cur_prime);
		end else if (pick == 2) begin
			px = 16'd0;
			py = 16'd0;
		end
		k = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
		send_request(1'($urandom_range(0, 1)), px, py, qx, qy, k);
	endtask

	task automatic random_phase(input int count);
		repeat (count) random_request();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = ecpa_pkg::CFG_PRIME;
		cfg_data = 16'd0;
		in_chan.valid = 1'b0;
		in_chan.mode = 1'b0;
		in_chan.p_x = 16'd0;
		in_chan.p_y = 16'd0;
		in_chan.q_x = 16'd0;
		in_chan.q_y = 16'd0;
		in_chan.scalar = 16'd0;
		send_idle = 0;
		recv_idle = 0;
		add_count = 0;
		scale_count = 0;
		cur_prime = 16'd97;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset curve p=97, a=2
		send_request(1'b0, 16'd3, 16'd6, 16'd80, 16'd10, 16'd0);   // plain sum
		send_request(1'b0, 16'd0, 16'd0, 16'd3, 16'd6, 16'd0);     // infinity + Q
		send_request(1'b0, 16'd3, 16'd6, 16'd0, 16'd0, 16'd0);     // P + infinity
		send_request(1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);     // both infinity
		send_request(1'b0, 16'd3, 16'd6, 16'd3, 16'd6, 16'd0);     // doubling
		send_request(1'b0, 16'd3, 16'd6, 16'd3, 16'd91, 16'd0);    // P + (-P)
		send_request(1'b0, 16'd5, 16'd0, 16'd5, 16'd0, 16'd0);     // double with y zero
		send_request(1'b0, 16'd100, 16'd103, 16'hFFFF, 16'hFFFF, 16'd0); // unreduced
		send_request(1'b0, 16'd97, 16'd97, 16'd3, 16'd6, 16'd0);   // reduces to infinity
		send_request(1'b1, 16'd3, 16'd6, 16'd0, 16'd0, 16'd0);     // scalar zero
		send_request(1'b1, 16'd3, 16'd6, 16'd0, 16'd0, 16'd1);
		send_request(1'b1, 16'd3, 16'd6, 16'd0, 16'd0, 16'd5);
		send_request(1'b1, 16'd3, 16'd6, 16'd0, 16'd0, 16'hFFFF);  // all scalar bits
		send_request(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd77);    // k * infinity
		send_request(1'b1, 16'd1, 16'd1, 16'hFFFF, 16'hFFFF, 16'd9); // off the curve
		// largest 16-bit prime, coefficient at its top
		set_curve(16'd65521, 16'hFFFF);
		send_request(1'b0, 16'd65520, 16'd1, 16'd12345, 16'd65520, 16'd0);
		send_request(1'b1, 16'd65520, 16'd65520, 16'd0, 16'd0, 16'h8001);
		// modulus below two gives infinity everywhere
		set_curve(16'd0, 16'd0);
		send_request(1'b0, 16'd3, 16'd6, 16'd8, 16'd1, 16'd0);
		set_curve(16'd1, 16'd5);
		send_request(1'b1, 16'd3, 16'd6, 16'd0, 16'd0, 16'd3);
		// composite modulus: denominator without inverse
		set_curve(16'hFFFF, 16'hFFFF);
		send_request(1'b0, 16'd0, 16'd1, 16'd3, 16'd5, 16'd0);
		send_request(1'b1, 16'd2, 16'd7, 16'd0, 16'd0, 16'd12);
		// smallest odd prime
		set_curve(16'd3, 16'd0);
		send_request(1'b0, 16'd1, 16'd1, 16'd1, 16'd1, 16'd0);
		send_request(1'b1, 16'd2, 16'd1, 16'd0, 16'd0, 16'd6);

		// random: sender mostly busy, receiver mostly stalled
		send_idle = 29;
		recv_idle = 80;
		set_curve(16'd97, 16'd2);
		random_phase(40);
		set_curve(16'd65521, 16'd3);
		random_phase(25);
		// then the reverse
		send_idle = 80;
		recv_idle = 29;
		set_curve(16'd23, 16'd1);
		random_phase(40);
		set_curve(16'd4097, 16'd100);
		random_phase(25);
		// then no idling at all
		send_idle = 0;
		recv_idle = 0;
		set_curve(16'd7, 16'd6);
		random_phase(35);
		set_curve(16'd40009, 16'd0);
		random_phase(35);

		in_chan.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (2000) @(posedge clk);
		$display("Covered %0d point additions and %0d scalar multiplications", add_count,
			scale_count);
		$display("over twelve curve settings, moduli 0 to 65535, with stalls on both sides.");
		if (fail_count == 0) begin
			$display("** ec_point_add_scalar_mult_unit: PASSED **");
		end else begin
			$display("** ec_point_add_scalar_mult_unit: FAILED **");
		end
		$finish;
	end

	// watchdog
	initial begin
		#400_000_000;
		$display("timeout with %0d results outstanding", pending);
		$display("** ec_point_add_scalar_mult_unit: FAILED **");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/ecpa_pkg.sv
design/ecpa_if.sv
design/ecpa_field_unit.sv
design/ec_point_add_scalar_mult_unit.sv
sim/ec_point_checker.sv
sim/tb_top.sv
